// ----- rtl/tmss_pkg.sv -----
// Shared types and constants for the trimmed-mean step smoother.
package tmss_pkg;

	localparam int WINDOW_DEPTH_DEF = 11;
	localparam int DATA_W = 32;
	localparam int LERP_W = 17;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LERP     = 3'd3;

	// Reset values of the configuration registers.
	localparam logic [DATA_W-1:0] SPEED_RST    = 32'h0001_0000;
	localparam logic [DATA_W-1:0] MIN_STEP_RST = 32'h0000_0000;
	localparam logic [DATA_W-1:0] MAX_STEP_RST = 32'hFFFF_FFFF;
	localparam logic [LERP_W-1:0] LERP_RST     = 17'd13107;

	// Trim range thresholds on the fill count.
	localparam int TRIM_ALL_BELOW = 7;
	localparam int TRIM_ONE_BELOW = 10;
	localparam int TRIM_FIRST_FULL = 2;
	localparam int TRIM_LAST_FULL = 8;

	// Item kinds.
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	// Operation of one cell in a cycle.
	typedef enum logic [2:0] {
		CM_HOLD,
		CM_PUSH,
		CM_LOAD,
		CM_SORT_EVEN,
		CM_SORT_ODD,
		CM_DRAIN
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
	} cell_ctl_t;

	// One entry of the sorting row; an invalid entry ranks above all values.
	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] val;
	} sort_ent_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_PUSH,
		ST_LOAD,
		ST_SORT,
		ST_DRAIN,
		ST_DIV,
		ST_BLEND_MUL,
		ST_BLEND_ADD,
		ST_OUT
	} state_t;

	// True when entry a ranks above entry b.
	function automatic logic ent_gt(sort_ent_t a, sort_ent_t b);
		logic r;
		if (a.vld != b.vld) begin
			r = b.vld;
		end else begin
			r = (a.val > b.val);
		end
		return r;
	endfunction

endpackage

// ----- rtl/tmss_cell.sv -----
// One cell of the window row: an age-ordered slot and a sorting slot.
module tmss_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmss_pkg::cell_ctl_t   ctl,
	input  logic                  odd_pos,
	input  logic [31:0]           age_in,
	input  logic                  age_vld,
	input  tmss_pkg::sort_ent_t   left_ent,
	input  tmss_pkg::sort_ent_t   right_ent,
	output logic [31:0]           age_out,
	output tmss_pkg::sort_ent_t   ent_out
);
	import tmss_pkg::*;

	logic [DATA_W-1:0] age_q;
	sort_ent_t         ent_q;
	sort_ent_t         ent_d;
	logic              pair_right;

	// In a sort cycle a cell pairs with its right or left neighbor by parity.
	always_comb begin
		pair_right = (ctl.mode == CM_SORT_EVEN) ? !odd_pos : odd_pos;
		ent_d = ent_q;
		case (ctl.mode)
			CM_LOAD: begin
				ent_d.vld = age_vld;
				ent_d.val = age_q;
			end
			CM_SORT_EVEN, CM_SORT_ODD: begin
				if (pair_right) begin
					ent_d = ent_gt(ent_q, right_ent) ? right_ent : ent_q;
				end else begin
					ent_d = ent_gt(left_ent, ent_q) ? left_ent : ent_q;
				end
			end
			CM_DRAIN: ent_d = right_ent;
			default: ent_d = ent_q;
		endcase
	end

	// Age slot shifts on a push; sorting slot follows the mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= ent_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mode == CM_PUSH) begin
			age_q <= age_in;
		end
	end

	assign age_out = age_q;
	assign ent_out = ent_q;

endmodule

// ----- rtl/tmss_div.sv -----
// Restoring divider: wide sum by a small count, one quotient bit per cycle.
module tmss_div #(
	parameter int NUM_W = 36,
	parameter int DEN_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [31:0]      quot
);
	import tmss_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic             take;

	// One trial subtraction per cycle.
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		take = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quot_q <= {quot_q[NUM_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q[DATA_W-1:0];

endmodule

// ----- rtl/trimmed_mean_step_smoother_unit.sv -----
// Top level of the trimmed-mean step smoother.
//
// Samples enter on the s_axis channel: tuser carries the kind (sample or
// clear) and tdata the raw step. Results leave on the m_axis channel, one
// smoothed step per sample; a clear item empties the history and gives
// nothing. Registers are written through the cfg channel, which is always
// ready and should be used only while the block is idle.
// One item is handled at a time. A sample scales through a 32x32 multiplier,
// is clamped and pushed into a row of window cells, sorted there by
// odd-even transposition, drained one entry per cycle into an
// accumulator, then divided by the trim count in a restoring divider and
// blended through one multiply and one add. The first sample after reset
// or clear skips the sort and yields its clamped value.
// The next request is accepted in the cycle after the result is loaded
// into the output register.
// The finished result sits in an output register, so a stalled receiver
// holds only that result; a new item is accepted meanwhile, and its result
// waits in the last stage until the register frees.
// Reset empties the history, clears the last output and restores the
// register defaults.
module trimmed_mean_step_smoother_unit #(
	parameter int WINDOW_DEPTH = tmss_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [31:0]                   s_axis_tdata,  // [31:0] raw_step
	input  logic                          s_axis_tuser,  // [0] kind
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [31:0]                   m_axis_tdata,  // [31:0] smoothed_step
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tmss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import tmss_pkg::*;

	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int IW = $clog2(WINDOW_DEPTH);
	localparam int SUM_W = DATA_W + CW;
	localparam int TC_W = 3;

	// Configuration registers.
	logic [DATA_W-1:0] speed_q, min_q, max_q;
	logic [LERP_W-1:0] lerp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RST;
			min_q <= MIN_STEP_RST;
			max_q <= MAX_STEP_RST;
			lerp_q <= LERP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SPEED: speed_q <= cfg_data;
				REG_MIN_STEP: min_q <= cfg_data;
				REG_MAX_STEP: max_q <= cfg_data;
				REG_LERP: lerp_q <= cfg_data[LERP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	state_t state_q, state_d;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     sc_q;
	logic [CW-1:0]     k_q;
	logic [IW-1:0]     first_q, last_q;
	logic [TC_W-1:0]   tcnt_q;
	logic [63:0]       prod_q;
	logic [DATA_W-1:0] val_q, last_out_q, res_q, out_q;
	logic [SUM_W-1:0]  sum_q;
	logic signed [49:0] bprod_q;
	logic              out_vld_q;
	logic              accept, div_start, div_busy, out_load;
	logic [DATA_W-1:0] mean;
	cell_ctl_t         cctl;
	logic [47:0]       scaled;
	logic [DATA_W-1:0] clamped;
	logic [IW-1:0]     first_d, last_d;
	logic signed [32:0] diff;
	logic signed [34:0] bsum;

	logic [DATA_W-1:0] age_w [WINDOW_DEPTH];
	sort_ent_t         ent_w [WINDOW_DEPTH];
	sort_ent_t         lo_ent, hi_ent;

	assign accept = s_axis_tvalid && s_axis_tready;

	// Next state and cell control.
	always_comb begin
		state_d = state_q;
		cctl.mode = CM_HOLD;
		div_start = 1'b0;
		out_load = 1'b0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && s_axis_tuser == KIND_SAMPLE) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: state_d = ST_PUSH;
			ST_PUSH: begin
				cctl.mode = CM_PUSH;
				state_d = (fill_q == '0) ? ST_OUT : ST_LOAD;
			end
			ST_LOAD: begin
				cctl.mode = CM_LOAD;
				state_d = ST_SORT;
			end
			ST_SORT: begin
				cctl.mode = sc_q[0] ? CM_SORT_ODD : CM_SORT_EVEN;
				if (sc_q == CW'(WINDOW_DEPTH - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cctl.mode = CM_DRAIN;
				if (k_q == CW'(last_q)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				// The drain counter is still nonzero only in the first divide cycle,
				// when the sum holds its last term.
				div_start = (k_q != '0);
				if (!div_busy && !div_start) begin
					state_d = ST_BLEND_MUL;
				end
			end
			ST_BLEND_MUL: state_d = ST_BLEND_ADD;
			ST_BLEND_ADD: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_vld_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scaling and clamp; an inverted range tests the lower bound first.
	always_comb begin
		scaled = prod_q[63:16];
		if (scaled < {16'd0, min_q}) begin
			clamped = min_q;
		end else if (scaled > {16'd0, max_q}) begin
			clamped = max_q;
		end else begin
			clamped = scaled[DATA_W-1:0];
		end
	end

	// Trim range from the fill count after the push.
	always_comb begin
		if (fill_q < CW'(TRIM_ALL_BELOW)) begin
			first_d = '0;
			last_d = IW'(fill_q - 1'b1);
		end else if (fill_q < CW'(TRIM_ONE_BELOW)) begin
			first_d = IW'(1);
			last_d = IW'(fill_q - CW'(2));
		end else begin
			first_d = IW'(TRIM_FIRST_FULL);
			last_d = IW'(TRIM_LAST_FULL);
		end
	end

	// History control: fill count, last output and step counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			last_out_q <= '0;
			sc_q <= '0;
			k_q <= '0;
		end else begin
			if (accept && s_axis_tuser == KIND_CLEAR) begin
				fill_q <= '0;
			end
			if (state_q == ST_PUSH) begin
				if (fill_q == '0) begin
					last_out_q <= val_q;
				end
				if (fill_q != CW'(WINDOW_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (state_q == ST_OUT) begin
				last_out_q <= res_q;
			end
			sc_q <= (state_q == ST_SORT) ? sc_q + 1'b1 : '0;
			k_q <= (state_q == ST_DRAIN) ? k_q + 1'b1 : '0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			prod_q <= 64'(s_axis_tdata) * 64'(speed_q);
		end
		if (state_q == ST_CLAMP) begin
			val_q <= clamped;
		end
		if (state_q == ST_PUSH) begin
			res_q <= val_q;
		end
		if (state_q == ST_LOAD) begin
			first_q <= first_d;
			last_q <= last_d;
			tcnt_q <= TC_W'(last_d - first_d + 1'b1);
			sum_q <= '0;
		end
		if (state_q == ST_DRAIN && k_q >= CW'(first_q)) begin
			sum_q <= sum_q + SUM_W'(ent_w[0].val);
		end
		if (state_q == ST_BLEND_MUL) begin
			bprod_q <= 50'(diff) * 50'($signed({1'b0, lerp_q}));
		end
		if (state_q == ST_BLEND_ADD) begin
			if (bsum < 0) begin
				res_q <= '0;
			end else if (bsum > 35'sh0_FFFF_FFFF) begin
				res_q <= '1;
			end else begin
				res_q <= bsum[DATA_W-1:0];
			end
		end
	end

	// Blend: floor of the product over 65536 is an arithmetic shift.
	always_comb begin
		diff = $signed({1'b0, mean}) - $signed({1'b0, last_out_q});
		bsum = $signed({3'b000, last_out_q}) + 35'(bprod_q >>> 16);
	end

	// Row of window cells; the ends see neutral neighbors.
	assign lo_ent = '{vld: 1'b1, val: '0};
	assign hi_ent = '{vld: 1'b0, val: '1};

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		tmss_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cctl),
			.odd_pos  (1'(i % 2)),
			.age_in   ((i == 0) ? val_q : age_w[(i == 0) ? 0 : i-1]),
			.age_vld  (CW'(i) < fill_q),
			.left_ent ((i == 0) ? lo_ent : ent_w[(i == 0) ? 0 : i-1]),
			.right_ent((i == WINDOW_DEPTH-1) ? hi_ent :
				ent_w[(i == WINDOW_DEPTH-1) ? i : i+1]),
			.age_out  (age_w[i]),
			.ent_out  (ent_w[i])
		);
	end

	tmss_div #(
		.NUM_W(SUM_W),
		.DEN_W(TC_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (sum_q),
		.den   (tcnt_q),
		.busy  (div_busy),
		.quot  (mean)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_q;

	// Checks.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(WINDOW_DEPTH)) else $error("fill count above depth");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_DIV) else $error("divider busy outside divide");
	a_load_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> fill_q >= CW'(2)) else $error("sort with short window");

endmodule
